FILE: hw/rtl/rail_power_sequencer_macros.svh
// Assertion macros used by the checker of the rail sequencer.
`ifndef RAIL_POWER_SEQUENCER_MACROS_SVH
`define RAIL_POWER_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/rps_pkg.sv
package rps_pkg;

   // Field and port widths
   localparam int NUM_RAILS  = 4;
   localparam int RAIL_W     = 2;
   localparam int THRESH_W   = 16;
   localparam int ADC_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Command codes
   typedef enum logic [1:0] {
      CMD_CONV = 2'd0,
      CMD_UP   = 2'd1,
      CMD_DOWN = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // Reported sequencer status
   typedef enum logic [1:0] {
      SEQ_OFF     = 2'd0,
      SEQ_RUNNING = 2'd1,
      SEQ_ON      = 2'd2,
      SEQ_FAULTED = 2'd3
   } seq_code_type;

   // Fault codes: none, or a base plus the rail number
   localparam logic [3:0] FAULT_NONE    = 4'd0;
   localparam logic [3:0] FAULT_UP_BASE = 4'd1;
   localparam logic [3:0] FAULT_DN_BASE = 4'd5;

   // Rail numbers at the ends of the sequence
   localparam logic [RAIL_W-1:0] RAIL_FIRST = 2'd0;
   localparam logic [RAIL_W-1:0] RAIL_LAST  = 2'd3;

   typedef logic [NUM_RAILS-1:0][THRESH_W-1:0] thresh_arr_type;

   // One input beat
   typedef struct packed {
      logic [1:0]       cmd;
      logic [ADC_W-1:0] adc_value;
      logic             adc_ok;
   } item_type;

   // One result beat
   typedef struct packed {
      logic [NUM_RAILS-1:0] rail_enables;
      logic                 measure_req;
      logic [RAIL_W-1:0]    measure_rail;
      logic [3:0]           fault_code;
      logic [1:0]           seq_state;
   } result_type;

endpackage

FILE: hw/rtl/rps_if.sv
// Input channel: commands and conversion results
interface rps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] adc_value;
   logic        adc_ok;

   modport source (output valid, output cmd, output adc_value, output adc_ok, input ready);
   modport sink (input valid, input cmd, input adc_value, input adc_ok, output ready);
endinterface

// Result channel: rail enables and sequencer status
interface rps_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] rail_enables;
   logic       measure_req;
   logic [1:0] measure_rail;
   logic [3:0] fault_code;
   logic [1:0] seq_state;

   modport source (output valid, output rail_enables, output measure_req,
                   output measure_rail, output fault_code, output seq_state, input ready);
   modport sink (input valid, input rail_enables, input measure_req,
                 input measure_rail, input fault_code, input seq_state, output ready);
endinterface

FILE: hw/rtl/rps_csr.sv
module rps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rps_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rps_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rps_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output rps_pkg::thresh_arr_type          thresh
);
   import rps_pkg::*;

   thresh_arr_type    thresh_ff;
   logic [RAIL_W-1:0] reg_idx;
   logic              wr_en;

   // Word-aligned register select
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Threshold registers, written in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (wr_en) begin
         thresh_ff[reg_idx] <= pwdata[THRESH_W-1:0];
      end
   end

   // Read back, zero extended
   assign prdata = CSR_DATA_W'(thresh_ff[reg_idx]);
   assign thresh = thresh_ff;

endmodule

FILE: hw/rtl/rps_seq.sv
module rps_seq #(
   parameter int ADC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_vld,
   input  rps_pkg::item_type       item,
   input  rps_pkg::thresh_arr_type thresh,
   output logic                    item_take,
   output logic                    res_vld,
   input  logic                    res_ready,
   output rps_pkg::result_type     result
);
   import rps_pkg::*;

   typedef enum logic [4:0] {
      ST_OFF   = 5'b00001,
      ST_UP    = 5'b00010,
      ST_ON    = 5'b00100,
      ST_DN    = 5'b01000,
      ST_FAULT = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [RAIL_W-1:0]    rail_ff, rail_in;
   logic [NUM_RAILS-1:0] en_ff, en_in;
   logic [3:0]           fault_ff, fault_in;
   logic                 res_vld_ff, res_vld_in;
   result_type           result_ff, result_in;

   logic [ADC_BITS-1:0]  sample;
   logic [THRESH_W-1:0]  sample_ext;
   logic                 present;
   logic                 waiting;
   logic [1:0]           code;

   // Result register frees up when empty or being drained
   assign item_take  = item_vld && (!res_vld_ff || res_ready);
   assign res_vld_in = item_take || (res_vld_ff && !res_ready);

   // Rail reading against its threshold, only ADC_BITS of the code count
   assign sample     = item.adc_value[ADC_BITS-1:0];
   assign sample_ext = THRESH_W'(sample);
   assign present    = item.adc_ok && (sample_ext >= thresh[rail_ff]);

   // Sequencer next state for the beat in the input register
   always_comb begin
      state_in = state_ff;
      rail_in  = rail_ff;
      en_in    = en_ff;
      fault_in = fault_ff;
      if (item_take) begin
         unique case (state_ff)
            ST_OFF: begin
               if (item.cmd == CMD_UP) begin
                  en_in    = en_ff | 4'b0001;
                  rail_in  = RAIL_FIRST;
                  state_in = ST_UP;
               end
            end
            ST_ON: begin
               if (item.cmd == CMD_DOWN) begin
                  en_in    = en_ff & 4'b0111;
                  rail_in  = RAIL_LAST;
                  state_in = ST_DN;
               end
            end
            ST_UP: begin
               if (item.cmd == CMD_CONV) begin
                  if (!present) begin
                     fault_in = FAULT_UP_BASE + 4'(rail_ff);
                     state_in = ST_FAULT;
                  end else if (rail_ff != RAIL_LAST) begin
                     en_in   = en_ff | NUM_RAILS'(4'b0010 << rail_ff);
                     rail_in = rail_ff + 2'd1;
                  end else begin
                     state_in = ST_ON;
                  end
               end
            end
            ST_DN: begin
               if (item.cmd == CMD_CONV) begin
                  if (present) begin
                     fault_in = FAULT_DN_BASE + 4'(rail_ff);
                     state_in = ST_FAULT;
                  end else if (rail_ff != RAIL_FIRST) begin
                     en_in   = en_ff & ~NUM_RAILS'(4'b0001 << (rail_ff - 2'd1));
                     rail_in = rail_ff - 2'd1;
                  end else begin
                     state_in = ST_OFF;
                  end
               end
            end
            ST_FAULT: begin
               state_in = ST_FAULT;
            end
            default: begin
               state_in = ST_FAULT;
            end
         endcase
      end
   end

   // Status code and result beat from the updated state
   always_comb begin
      unique case (state_in)
         ST_OFF:   code = SEQ_OFF;
         ST_ON:    code = SEQ_ON;
         ST_UP:    code = SEQ_RUNNING;
         ST_DN:    code = SEQ_RUNNING;
         default:  code = SEQ_FAULTED;
      endcase
      waiting                = (state_in == ST_UP) || (state_in == ST_DN);
      result_in.rail_enables = en_in;
      result_in.measure_req  = waiting;
      result_in.measure_rail = waiting ? rail_in : RAIL_FIRST;
      result_in.fault_code   = fault_in;
      result_in.seq_state    = code;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_OFF;
         rail_ff    <= RAIL_FIRST;
         en_ff      <= '0;
         fault_ff   <= FAULT_NONE;
         res_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rail_ff    <= rail_in;
         en_ff      <= en_in;
         fault_ff   <= fault_in;
         res_vld_ff <= res_vld_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (item_take) begin
         result_ff <= result_in;
      end
   end

   assign res_vld = res_vld_ff;
   assign result  = result_ff;

endmodule

FILE: hw/rtl/rail_power_sequencer.sv
// Four-rail supply sequencer. A power-up command enables the 15V, bias, 500V
// and H-bridge rails one at a time, each after a conversion of the previous
// rail reads at or above its threshold; power-down releases them in reverse
// order and checks each rail has gone. Every accepted beat returns exactly one
// result beat carrying the enables, the rail to convert next, the sticky fault
// code and the sequencer status. One beat per clock is taken while the result
// side is not stalled; each beat passes the input register, then the state
// update loads the result register. Thresholds are written over the APB
// port at byte addresses 0, 4, 8 and 12 and reset to zero; write them only
// while no beat is in flight. Only the low ADC_BITS bits of adc_value are
// compared. A fault holds until reset.
module rail_power_sequencer #(
   parameter int ADC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   rps_req_if.sink                        req_bus,
   rps_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rps_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rps_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import rps_pkg::*;

   thresh_arr_type thresh;
   item_type       item_in, item_ff;
   logic           in_vld_ff, in_vld_in;
   logic           item_take;
   logic           res_vld;
   result_type     result;

   rps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thresh  (thresh)
   );

   // Input register: takes a beat when empty or when its content moves on this cycle
   assign req_bus.ready = !in_vld_ff || item_take;
   assign in_vld_in     = req_bus.ready ? req_bus.valid : in_vld_ff;

   assign item_in.cmd       = req_bus.cmd;
   assign item_in.adc_value = req_bus.adc_value;
   assign item_in.adc_ok    = req_bus.adc_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         item_ff <= item_in;
      end
   end

   rps_seq #(
      .ADC_BITS (ADC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .item_vld  (in_vld_ff),
      .item      (item_ff),
      .thresh    (thresh),
      .item_take (item_take),
      .res_vld   (res_vld),
      .res_ready (rsp_bus.ready),
      .result    (result)
   );

   // Result channel
   assign rsp_bus.valid        = res_vld;
   assign rsp_bus.rail_enables = result.rail_enables;
   assign rsp_bus.measure_req  = result.measure_req;
   assign rsp_bus.measure_rail = result.measure_rail;
   assign rsp_bus.fault_code   = result.fault_code;
   assign rsp_bus.seq_state    = result.seq_state;

endmodule

FILE: hw/rtl/rps_checker.sv
`include "rail_power_sequencer_macros.svh"

module rps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_rail_enables,
   input logic       rsp_measure_req,
   input logic [1:0] rsp_measure_rail,
   input logic [3:0] rsp_fault_code,
   input logic [1:0] rsp_seq_state
);
   import rps_pkg::*;

   // A conversion is only asked for mid-sequence, and names no rail otherwise
   `RPS_ASSERT_NOW(a_req_in_seq, clock, reset, rsp_valid && rsp_measure_req, rsp_seq_state == SEQ_RUNNING, "measure request outside a sequence")
   `RPS_ASSERT_NOW(a_rail_idle, clock, reset, rsp_valid && !rsp_measure_req, rsp_measure_rail == 2'd0, "rail named without a request")

   // A latched fault is only reported with the faulted status
   `RPS_ASSERT_NOW(a_fault_state, clock, reset, rsp_valid && (rsp_fault_code != FAULT_NONE), rsp_seq_state == SEQ_FAULTED, "fault code without faulted status")

   // Fully on means every rail enabled
   `RPS_ASSERT_NOW(a_on_all, clock, reset, rsp_valid && (rsp_seq_state == SEQ_ON), rsp_rail_enables == 4'hF, "on with a rail disabled")

   // A stalled result beat holds
   `RPS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rail_enables) && $stable(rsp_fault_code) && $stable(rsp_seq_state), "stalled result beat changed")

endmodule

bind rail_power_sequencer rps_checker u_rps_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_rail_enables (rsp_bus.rail_enables),
   .rsp_measure_req  (rsp_bus.measure_req),
   .rsp_measure_rail (rsp_bus.measure_rail),
   .rsp_fault_code   (rsp_bus.fault_code),
   .rsp_seq_state    (rsp_bus.seq_state)
);

FILE: test/tb_rail_power_sequencer.sv
module tb_rail_power_sequencer;
   import rps_pkg::*;

   localparam int ADC_BITS = 16;
   localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((1 << ADC_BITS) - 1);

   // Threshold register addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH_15V  = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH_BIAS = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH_500V = 4'h8;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH_HV   = 4'hC;

   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SEGMENT_BEATS = 205;

   // Sequencer steps: power-up waits per rail, on, power-down waits per rail
   typedef enum logic [3:0] {
      ST_OFF, ST_UP_15V, ST_UP_BIAS, ST_UP_500V, ST_UP_HV, ST_ON,
      ST_DN_HV, ST_DN_500V, ST_DN_BIAS, ST_DN_15V, ST_FAULT
   } step_type;

   typedef struct packed {
      step_type   step;
      logic [3:0] en;
      logic [3:0] fault;
   } supply_type;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   rps_req_if req_bus ();
   rps_rsp_if rsp_bus ();

   rail_power_sequencer #(.ADC_BITS(ADC_BITS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [THRESH_W-1:0] thresh_set [NUM_RAILS];
   supply_type live = '{step: ST_OFF, en: '0, fault: '0};   // at accepted beats
   supply_type plan = '{step: ST_OFF, en: '0, fault: '0};   // at queued beats
   item_type   cmd_backlog [$];
   result_type status_due [$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_given = 0;
   int hold_left = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   function automatic bit powering_up(step_type st);
      return st >= ST_UP_15V && st <= ST_UP_HV;
   endfunction

   function automatic bit powering_down(step_type st);
      return st >= ST_DN_HV && st <= ST_DN_15V;
   endfunction

   function automatic logic [RAIL_W-1:0] rail_of(step_type st);
      if (powering_up(st))
         return RAIL_W'(int'(st) - int'(ST_UP_15V));
      if (powering_down(st))
         return RAIL_W'(3 - (int'(st) - int'(ST_DN_HV)));
      return RAIL_FIRST;
   endfunction

   // Sequencer state after one beat
   function automatic supply_type next_supply(supply_type s, item_type it);
      logic [ADC_W-1:0]  level;
      logic [RAIL_W-1:0] rail;
      logic              present;
      level = it.adc_value & ADC_MASK;
      rail = rail_of(s.step);
      present = it.adc_ok && (level >= thresh_set[rail]);
      case (it.cmd)
         CMD_UP: begin
            if (s.step == ST_OFF) begin
               s.en[0] = 1'b1;
               s.step = ST_UP_15V;
            end
         end
         CMD_DOWN: begin
            if (s.step == ST_ON) begin
               s.en[3] = 1'b0;
               s.step = ST_DN_HV;
            end
         end
         CMD_CONV: begin
            if (powering_up(s.step)) begin
               if (!present) begin
                  s.fault = FAULT_UP_BASE + 4'(rail);
                  s.step = ST_FAULT;
               end else if (rail != RAIL_LAST) begin
                  s.en[int'(rail) + 1] = 1'b1;
                  s.step = step_type'(s.step + 1);
               end else begin
                  s.step = ST_ON;
               end
            end else if (powering_down(s.step)) begin
               if (present) begin
                  s.fault = FAULT_DN_BASE + 4'(rail);
                  s.step = ST_FAULT;
               end else if (rail != RAIL_FIRST) begin
                  s.en[int'(rail) - 1] = 1'b0;
                  s.step = step_type'(s.step + 1);
               end else begin
                  s.step = ST_OFF;
               end
            end
         end
         default: ;
      endcase
      return s;
   endfunction

   // Status beat reported for a given state
   function automatic result_type supply_status(supply_type s);
      result_type r;
      r.rail_enables = s.en;
      r.measure_req = powering_up(s.step) || powering_down(s.step);
      r.measure_rail = rail_of(s.step);
      r.fault_code = s.fault;
      if (s.step == ST_OFF)
         r.seq_state = SEQ_OFF;
      else if (s.step == ST_ON)
         r.seq_state = SEQ_ON;
      else if (r.measure_req)
         r.seq_state = SEQ_RUNNING;
      else
         r.seq_state = SEQ_FAULTED;
      return r;
   endfunction

   function automatic item_type mk(cmd_type cmd, logic [ADC_W-1:0] value, logic ok);
      item_type it;
      it.cmd = cmd;
      it.adc_value = value;
      it.adc_ok = ok;
      return it;
   endfunction

   function automatic item_type any_beat();
      return mk(cmd_type'($urandom_range(3)), ADC_W'($urandom), 1'($urandom));
   endfunction

   // Beat that moves the sequence along without a fault
   function automatic item_type on_track_beat(supply_type s);
      item_type            it;
      logic [THRESH_W-1:0] th;
      it = any_beat();
      th = thresh_set[rail_of(s.step)];
      if (s.step == ST_OFF) begin
         it.cmd = CMD_UP;
      end else if (s.step == ST_ON) begin
         it.cmd = CMD_DOWN;
      end else if (powering_up(s.step)) begin
         it.cmd = CMD_CONV;
         it.adc_ok = 1'b1;
         it.adc_value = ADC_W'($urandom_range(16'hFFFF, th));
      end else if (powering_down(s.step)) begin
         it.cmd = CMD_CONV;
         if (th == 0 || $urandom_range(1) == 0) begin
            it.adc_ok = 1'b0;
         end else begin
            it.adc_ok = 1'b1;
            it.adc_value = ADC_W'($urandom_range(th - 1, 0));
         end
      end else begin
         it.cmd = CMD_NONE;
      end
      return it;
   endfunction

   task automatic queue_beat(input item_type it);
      cmd_backlog.push_back(it);
      plan = next_supply(plan, it);
   endtask

   task automatic drain();
      while (cmd_backlog.size() != 0 || status_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Only called with no beat in flight
   task automatic set_thresholds(input logic [THRESH_W-1:0] t15v, tbias, t500v, thv);
      csr_write(ADDR_THRESH_15V, CSR_DATA_W'(t15v));
      csr_write(ADDR_THRESH_BIAS, CSR_DATA_W'(tbias));
      csr_write(ADDR_THRESH_500V, CSR_DATA_W'(t500v));
      csr_write(ADDR_THRESH_HV, CSR_DATA_W'(thv));
      thresh_set = '{t15v, tbias, t500v, thv};
   endtask

   task automatic random_thresholds();
      set_thresholds(THRESH_W'($urandom), THRESH_W'($urandom),
                     THRESH_W'($urandom), THRESH_W'($urandom));
   endtask

   // Mostly well-formed sequences, some ignored noise; never faults
   task automatic run_segment(input int beats_wanted);
      int         moved;
      item_type   it;
      supply_type after;
      moved = 0;
      while (moved < beats_wanted) begin
         if ($urandom_range(99) < 15) begin
            it = any_beat();
            after = next_supply(plan, it);
            if (after.step == ST_FAULT)
               it.cmd = CMD_NONE;
         end else begin
            it = on_track_beat(plan);
         end
         after = next_supply(plan, it);
         if (after.step != plan.step)
            moved++;
         queue_beat(it);
      end
      drain();
   endtask

   // Input side: present the oldest queued beat, predict on acceptance
   always @(posedge clock) begin
      item_type sent;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.cmd <= CMD_NONE;
         req_bus.adc_value <= '0;
         req_bus.adc_ok <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            sent = cmd_backlog.pop_front();
            live = next_supply(live, sent);
            status_due.push_back(supply_status(live));
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the beat until taken
         end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.cmd <= cmd_backlog[0].cmd;
            req_bus.adc_value <= cmd_backlog[0].adc_value;
            req_bus.adc_ok <= cmd_backlog[0].adc_ok;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result side: check each beat against the oldest prediction
   always @(posedge clock) begin
      result_type seen, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.rail_enables = rsp_bus.rail_enables;
            seen.measure_req = rsp_bus.measure_req;
            seen.measure_rail = rsp_bus.measure_rail;
            seen.fault_code = rsp_bus.fault_code;
            seen.seq_state = rsp_bus.seq_state;
            if (status_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected status beat: en=%h req=%b rail=%0d fault=%0d seq=%0d",
                           seen.rail_enables, seen.measure_req, seen.measure_rail,
                           seen.fault_code, seen.seq_state);
               fail_count++;
            end else begin
               want = status_due.pop_front();
               if (seen.rail_enables !== want.rail_enables ||
                   seen.measure_req !== want.measure_req ||
                   seen.measure_rail !== want.measure_rail ||
                   seen.fault_code !== want.fault_code ||
                   seen.seq_state !== want.seq_state) begin
                  if (fail_count < 10)
                     $display({"status mismatch: expected en=%h req=%b rail=%0d fault=%0d ",
                               "seq=%0d, got en=%h req=%b rail=%0d fault=%0d seq=%0d"},
                              want.rail_enables, want.measure_req, want.measure_rail,
                              want.fault_code, want.seq_state,
                              seen.rail_enables, seen.measure_req, seen.measure_rail,
                              seen.fault_code, seen.seq_state);
                  fail_count++;
               end
            end
         end
         // long hold-off when asked, else random stalls
         if (hold_given != hold_asked) begin
            hold_given = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int                  kind;
      int                  rail;
      step_type            target;
      item_type            it;
      logic [THRESH_W-1:0] th;

      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      thresh_set = '{default: '0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: exact thresholds, timeouts, ignored commands, full up and down
      send_idle_pct = 10;
      recv_stall_pct = 70;
      set_thresholds(16'h1000, 16'h0001, 16'hFFFF, 16'h0000);
      queue_beat(mk(CMD_CONV, 16'hFFFF, 1'b1));   // no conversion awaited
      queue_beat(mk(CMD_DOWN, 16'h0000, 1'b0));   // down while off
      queue_beat(mk(CMD_NONE, 16'hFFFF, 1'b1));
      queue_beat(mk(CMD_UP, 16'h0000, 1'b0));
      queue_beat(mk(CMD_UP, 16'hFFFF, 1'b1));     // up while sequencing
      queue_beat(mk(CMD_DOWN, 16'hFFFF, 1'b1));   // no abort of a sequence
      queue_beat(mk(CMD_CONV, 16'h1000, 1'b1));   // exactly at threshold
      queue_beat(mk(CMD_CONV, 16'h0001, 1'b1));
      queue_beat(mk(CMD_CONV, 16'hFFFF, 1'b1));
      queue_beat(mk(CMD_CONV, 16'h0000, 1'b1));   // zero threshold, now on
      queue_beat(mk(CMD_UP, 16'h0000, 1'b1));     // up while on
      queue_beat(mk(CMD_CONV, 16'hFFFF, 1'b1));   // no conversion awaited
      queue_beat(mk(CMD_NONE, 16'h0000, 1'b0));
      queue_beat(mk(CMD_DOWN, 16'h0000, 1'b1));
      queue_beat(mk(CMD_CONV, 16'hFFFF, 1'b0));   // timeout reads as absent
      queue_beat(mk(CMD_CONV, 16'hFFFE, 1'b1));
      queue_beat(mk(CMD_CONV, 16'h0000, 1'b1));
      queue_beat(mk(CMD_CONV, 16'h0FFF, 1'b1));   // just below, back to off
      queue_beat(mk(CMD_DOWN, 16'hFFFF, 1'b1));
      queue_beat(mk(CMD_UP, 16'hFFFF, 1'b0));
      queue_beat(mk(CMD_CONV, 16'hFFFF, 1'b1));
      drain();

      // Sender idles little, receiver a lot
      set_thresholds(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_segment(SEGMENT_BEATS);
      random_thresholds();
      hold_asked++;   // output blocked while input keeps coming
      run_segment(SEGMENT_BEATS);

      // Sender idles a lot, receiver little
      send_idle_pct = 70;
      recv_stall_pct = 10;
      set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_segment(SEGMENT_BEATS);
      random_thresholds();
      run_segment(SEGMENT_BEATS);

      // No idling
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_thresholds();
      run_segment(SEGMENT_BEATS);
      set_thresholds(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      run_segment(SEGMENT_BEATS);

      // One sticky fault on a random rail and direction, then ignored commands
      kind = $urandom_range(1);
      rail = $urandom_range(3);
      target = kind ? step_type'(int'(ST_DN_HV) + 3 - rail)
                    : step_type'(int'(ST_UP_15V) + rail);
      while (plan.step != target)
         queue_beat(on_track_beat(plan));
      th = thresh_set[rail];
      it = mk(CMD_CONV, ADC_W'($urandom), 1'b1);
      if (kind != 0)
         it.adc_value = ADC_W'($urandom_range(16'hFFFF, th));   // rail still present
      else if (th == 0 || $urandom_range(1) == 0)
         it.adc_ok = 1'b0;                                     // conversion timed out
      else
         it.adc_value = ADC_W'($urandom_range(th - 1, 0));     // reading too low
      queue_beat(it);
      repeat (12)
         queue_beat(any_beat());
      drain();

      repeat (8) @(posedge clock);
      if (fail_count == 0 && status_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rps_pkg.sv
hw/rtl/rps_if.sv
hw/rtl/rps_csr.sv
hw/rtl/rps_seq.sv
hw/rtl/rail_power_sequencer.sv
hw/rtl/rps_checker.sv
test/tb_rail_power_sequencer.sv
